// ===== design/cdet_pkg.sv =====
package cdet_pkg;

    // Result codes, in detection priority order
    typedef enum logic [2:0] {
        ENC_UTF8    = 3'd0,
        ENC_GB2312  = 3'd1,
        ENC_BIG5    = 3'd2,
        ENC_GBK     = 3'd3,
        ENC_UNKNOWN = 3'd4
    } t_encoding;

    // UTF-8 pending trail count
    typedef logic [2:0] t_utf8_cnt;

    // Double-byte scheme byte ranges
    localparam logic [7:0] GB_LEAD_LO    = 8'hA1;
    localparam logic [7:0] GB_LEAD_HI    = 8'hF7;
    localparam logic [7:0] GB_TRAIL_LO   = 8'hA1;
    localparam logic [7:0] GB_TRAIL_HI   = 8'hFE;
    localparam logic [7:0] B5_LEAD_LO    = 8'hA1;
    localparam logic [7:0] B5_LEAD_HI    = 8'hF9;
    localparam logic [7:0] B5_TRAIL1_LO  = 8'h40;
    localparam logic [7:0] B5_TRAIL1_HI  = 8'h7E;
    localparam logic [7:0] B5_TRAIL2_LO  = 8'hA1;
    localparam logic [7:0] B5_TRAIL2_HI  = 8'hFE;
    localparam logic [7:0] GBK_LEAD_LO   = 8'h81;
    localparam logic [7:0] GBK_LEAD_HI   = 8'hFE;
    localparam logic [7:0] GBK_TRAIL_LO  = 8'h40;
    localparam logic [7:0] GBK_TRAIL_HI  = 8'hFE;

endpackage

// ===== design/charset_detect_utf8_gb_big5.sv =====
// Channel   Direction  Signals                              Moves
// ------    ---------  -----------------------------------  -------------------------
// in        sink       i_valid, o_stall, i_data_byte,       one byte of a string
//                      i_last_byte
// out       source     o_valid, i_stall, o_encoding         one verdict per string
//
// One byte is taken per cycle, back to back, while o_stall is low.
// The verdict sits in the output register in the cycle after the last byte is taken.
// The only thing that holds the input is a verdict still waiting downstream: o_stall
// is high only while o_valid is high and i_stall is high.
// Reset (synchronous, active low) clears all validator state and the output valid.
module charset_detect_utf8_gb_big5 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cdet_pkg::t_encoding  o_encoding
);
    import cdet_pkg::*;

    // Validator state: a pending trail count and a sticky fail flag per scheme.
    t_utf8_cnt r_utf8_pend, n_utf8_pend;
    logic      r_utf8_fail, n_utf8_fail;
    logic      r_gb_pend,   n_gb_pend;
    logic      r_gb_fail,   n_gb_fail;
    logic      r_b5_pend,   n_b5_pend;
    logic      r_b5_fail,   n_b5_fail;
    logic      r_gbk_pend,  n_gbk_pend;
    logic      r_gbk_fail,  n_gbk_fail;

    logic      r_out_valid;
    t_encoding r_out_enc, n_out_enc;

    logic      accept;
    logic      gb_lead, gb_trail, b5_lead, b5_trail, gbk_lead, gbk_trail;
    t_utf8_cnt utf8_need;
    logic      utf8_bad_lead;

    // Output register frees itself when its verdict is taken this cycle.
    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_encoding = r_out_enc;

    // Byte class decodes
    assign gb_lead   = (i_data_byte >= GB_LEAD_LO)   && (i_data_byte <= GB_LEAD_HI);
    assign gb_trail  = (i_data_byte >= GB_TRAIL_LO)  && (i_data_byte <= GB_TRAIL_HI);
    assign b5_lead   = (i_data_byte >= B5_LEAD_LO)   && (i_data_byte <= B5_LEAD_HI);
    assign b5_trail  = ((i_data_byte >= B5_TRAIL1_LO) && (i_data_byte <= B5_TRAIL1_HI))
                    || ((i_data_byte >= B5_TRAIL2_LO) && (i_data_byte <= B5_TRAIL2_HI));
    assign gbk_lead  = (i_data_byte >= GBK_LEAD_LO)  && (i_data_byte <= GBK_LEAD_HI);
    assign gbk_trail = (i_data_byte >= GBK_TRAIL_LO) && (i_data_byte <= GBK_TRAIL_HI);

    // UTF-8 lead byte: trail bytes it announces (no overlong check).
    always_comb begin
        utf8_need     = 3'd0;
        utf8_bad_lead = 1'b0;
        unique casez (i_data_byte)
            8'b0???????: utf8_need = 3'd0;
            8'b110?????: utf8_need = 3'd1;
            8'b1110????: utf8_need = 3'd2;
            8'b11110???: utf8_need = 3'd3;
            8'b111110??: utf8_need = 3'd4;
            8'b1111110?: utf8_need = 3'd5;
            default:     utf8_bad_lead = 1'b1;
        endcase
    end

    // Shared double-byte step: returns {pend, fail}.
    function automatic logic [1:0] dbcs_step(input logic pend, input logic fail,
                                             input logic hi_bit, input logic lead_ok,
                                             input logic trail_ok);
        logic [1:0] res;
        res = {pend, fail};
        if (!fail) begin
            if (pend) begin
                res = trail_ok ? 2'b00 : 2'b01;
            end else if (hi_bit) begin
                res = lead_ok ? 2'b10 : 2'b01;
            end
        end
        return res;
    endfunction

    always_comb begin
        n_utf8_pend = r_utf8_pend;
        n_utf8_fail = r_utf8_fail;
        if (!r_utf8_fail) begin
            if (r_utf8_pend != 3'd0) begin
                // An expected trail is never re-read as a lead.
                if (i_data_byte[7:6] == 2'b10) begin
                    n_utf8_pend = r_utf8_pend - 3'd1;
                end else begin
                    n_utf8_fail = 1'b1;
                end
            end else if (utf8_bad_lead) begin
                n_utf8_fail = 1'b1;
            end else begin
                n_utf8_pend = utf8_need;
            end
        end

        {n_gb_pend, n_gb_fail}   = dbcs_step(r_gb_pend, r_gb_fail, i_data_byte[7],
                                             gb_lead, gb_trail);
        {n_b5_pend, n_b5_fail}   = dbcs_step(r_b5_pend, r_b5_fail, i_data_byte[7],
                                             b5_lead, b5_trail);
        {n_gbk_pend, n_gbk_fail} = dbcs_step(r_gbk_pend, r_gbk_fail, i_data_byte[7],
                                             gbk_lead, gbk_trail);

        // Verdict: a truncated sequence (trail still pending) counts as a failure.
        if (!n_utf8_fail && n_utf8_pend == 3'd0) begin
            n_out_enc = ENC_UTF8;
        end else if (!n_gb_fail && !n_gb_pend) begin
            n_out_enc = ENC_GB2312;
        end else if (!n_b5_fail && !n_b5_pend) begin
            n_out_enc = ENC_BIG5;
        end else if (!n_gbk_fail && !n_gbk_pend) begin
            n_out_enc = ENC_GBK;
        end else begin
            n_out_enc = ENC_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf8_pend <= 3'd0;
            r_utf8_fail <= 1'b0;
            r_gb_pend   <= 1'b0;
            r_gb_fail   <= 1'b0;
            r_b5_pend   <= 1'b0;
            r_b5_fail   <= 1'b0;
            r_gbk_pend  <= 1'b0;
            r_gbk_fail  <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                // End of string: every validator back to its start state.
                r_utf8_pend <= 3'd0;
                r_utf8_fail <= 1'b0;
                r_gb_pend   <= 1'b0;
                r_gb_fail   <= 1'b0;
                r_b5_pend   <= 1'b0;
                r_b5_fail   <= 1'b0;
                r_gbk_pend  <= 1'b0;
                r_gbk_fail  <= 1'b0;
            end else begin
                r_utf8_pend <= n_utf8_pend;
                r_utf8_fail <= n_utf8_fail;
                r_gb_pend   <= n_gb_pend;
                r_gb_fail   <= n_gb_fail;
                r_b5_pend   <= n_b5_pend;
                r_b5_fail   <= n_b5_fail;
                r_gbk_pend  <= n_gbk_pend;
                r_gbk_fail  <= n_gbk_fail;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_out_enc <= n_out_enc;
        end
    end

endmodule

// ===== design/cdet_checker.sv =====
module cdet_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                i_last_byte,
    input logic                o_valid,
    input logic                i_stall,
    input cdet_pkg::t_encoding o_encoding
);
    import cdet_pkg::*;

    // Last byte taken: verdict shows next cycle.
    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_byte) |=> o_valid)
        else $error("no verdict after last byte");

    // Any other byte taken: no verdict appears.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_last_byte) |=> !o_valid)
        else $error("verdict without last byte");

    // Shown verdict is a defined code.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_encoding <= ENC_UNKNOWN))
        else $error("undefined encoding code");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("verdict dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_encoding))
        else $error("verdict changed while stalled");

endmodule

bind charset_detect_utf8_gb_big5 cdet_checker u_cdet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_last_byte (i_last_byte),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_encoding  (o_encoding)
);
